// File: src/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SPQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SPQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/spq_pkg.sv
package spq_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam int VAL_W    = 32;
  localparam int PRI_W    = 16;
  localparam int STAT_W   = 2;
  localparam int ECNT_W   = 5;

  localparam int IN_DATA_W  = 48; // value + priority, whole bytes
  localparam int OUT_DATA_W = 40; // removed value + count, padded to bytes

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_REMOVE = 1'b1;

  localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  // Broadcast to every cell in the row.
  typedef struct packed {
    logic                    ins;
    logic                    rem;
    logic [VAL_W-1:0]        value;
    logic signed [PRI_W-1:0] pri;
  } spq_cmd_t;

endpackage

// File: src/spq_cell.sv
module spq_cell (
  input  logic                            clk,
  input  spq_pkg::spq_cmd_t               cmd,
  input  logic                            occupied,
  input  logic                            le_prev,
  input  logic [spq_pkg::VAL_W-1:0]       left_val,
  input  logic signed [spq_pkg::PRI_W-1:0] left_pri,
  input  logic [spq_pkg::VAL_W-1:0]       right_val,
  input  logic signed [spq_pkg::PRI_W-1:0] right_pri,
  output logic                            le,
  output logic [spq_pkg::VAL_W-1:0]       val,
  output logic signed [spq_pkg::PRI_W-1:0] pri
);

  logic [spq_pkg::VAL_W-1:0]        val_r, val_nxt;
  logic signed [spq_pkg::PRI_W-1:0] pri_r, pri_nxt;

  // Insert point: first slot that is free or holds a key >= the new one.
  assign le = !occupied || ($signed(cmd.pri) <= $signed(pri_r));

  always_comb begin
    val_nxt = val_r;
    pri_nxt = pri_r;
    if (cmd.ins) begin
      if (le_prev) begin
        val_nxt = left_val;   // shift toward the tail
        pri_nxt = left_pri;
      end else if (le) begin
        val_nxt = cmd.value;
        pri_nxt = cmd.pri;
      end
    end else if (cmd.rem) begin
      val_nxt = right_val;    // shift toward the head
      pri_nxt = right_pri;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
    pri_r <= pri_nxt;
  end

  assign val = val_r;
  assign pri = pri_r;

endmodule

// File: src/sorted_priority_queue.sv
// sorted_priority_queue: min-first priority queue built as a row of shift cells.
// The result is registered and appears in the cycle after a request is accepted.
// Throughput: one request per cycle while the result side keeps up; every cell compares and shifts in parallel.
// Reset (rst_n low, synchronous): queue empties, no pending result; slot
// contents are left as they are and only read below the stored count.
`include "assert_macros.svh"

module sorted_priority_queue (
  input  logic                                clk,
  input  logic                                rst_n,
  // request channel
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [spq_pkg::IN_DATA_W-1:0]       in_tdata,  // [31:0] value, [47:32] priority_req
  input  logic [0:0]                          in_tuser,  // [0] mode
  // result channel
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [spq_pkg::OUT_DATA_W-1:0]      out_tdata, // [31:0] removed_value,
                                                         // [36:32] entry_count, rest zero
  output logic [spq_pkg::STAT_W-1:0]          out_tuser  // [1:0] status
);

  localparam int N = spq_pkg::CAPACITY;
  localparam int CW = spq_pkg::CNT_W;

  // ---------------------------------------------------------------- control
  logic          in_acc;
  logic          full, empty;
  logic [CW-1:0] count_r, count_nxt;
  logic          out_valid_r, out_valid_nxt;
  spq_pkg::spq_cmd_t cmd;

  // Output register decouples the two sides; a new request is taken whenever
  // the pending result leaves in the same cycle.
  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  assign full  = (count_r == CW'(N));
  assign empty = (count_r == '0);

  always_comb begin
    cmd.ins   = in_acc && (in_tuser[0] == spq_pkg::MODE_INSERT) && !full;
    cmd.rem   = in_acc && (in_tuser[0] == spq_pkg::MODE_REMOVE) && !empty;
    cmd.value = in_tdata[spq_pkg::VAL_W-1:0];
    cmd.pri   = in_tdata[spq_pkg::VAL_W +: spq_pkg::PRI_W];
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.ins) count_nxt = count_r + CW'(1);
    else if (cmd.rem) count_nxt = count_r - CW'(1);
  end

  // ---------------------------------------------------------------- cell row
  logic [N-1:0]                          le;
  logic [N-1:0]                          occ;
  logic [spq_pkg::VAL_W-1:0]             cval [N];
  logic signed [spq_pkg::PRI_W-1:0]      cpri [N];

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic                             le_prev;
    logic [spq_pkg::VAL_W-1:0]        lval, rval;
    logic signed [spq_pkg::PRI_W-1:0] lpri, rpri;

    assign occ[i] = (count_r > CW'(i));

    if (i == 0) begin : g_head
      assign le_prev = 1'b0;
      assign lval    = '0;
      assign lpri    = '0;
    end else begin : g_body
      assign le_prev = le[i-1];
      assign lval    = cval[i-1];
      assign lpri    = cpri[i-1];
    end

    if (i == N - 1) begin : g_tail
      // tail slot is free after any remove that reaches it
      assign rval = cval[i];
      assign rpri = cpri[i];
    end else begin : g_mid
      assign rval = cval[i+1];
      assign rpri = cpri[i+1];
    end

    spq_cell u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .occupied  (occ[i]),
      .le_prev   (le_prev),
      .left_val  (lval),
      .left_pri  (lpri),
      .right_val (rval),
      .right_pri (rpri),
      .le        (le[i]),
      .val       (cval[i]),
      .pri       (cpri[i])
    );
  end

  // ---------------------------------------------------------------- result
  logic [spq_pkg::STAT_W-1:0]    status_r, status_nxt;
  logic [spq_pkg::VAL_W-1:0]     rmval_r, rmval_nxt;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_acc) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;

    status_nxt = status_r;
    rmval_nxt  = rmval_r;
    if (in_acc) begin
      rmval_nxt = '0;
      if (in_tuser[0] == spq_pkg::MODE_INSERT) begin
        status_nxt = full ? spq_pkg::ST_FULL : spq_pkg::ST_DONE;
      end else if (empty) begin
        status_nxt = spq_pkg::ST_EMPTY;
      end else begin
        status_nxt = spq_pkg::ST_DONE;
        rmval_nxt  = cval[0];   // head holds the lowest priority
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      count_r     <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      count_r     <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    rmval_r  <= rmval_nxt;
  end

  // count shown after the operation; it is the register itself once updated
  assign out_tvalid = out_valid_r;
  assign out_tuser  = status_r;
  assign out_tdata  = {{(spq_pkg::OUT_DATA_W - spq_pkg::VAL_W - spq_pkg::ECNT_W){1'b0}},
                       spq_pkg::ECNT_W'(count_r), rmval_r};

  // ---------------------------------------------------------------- checks
  logic rem_on_empty;
  assign rem_on_empty = in_acc && (in_tuser[0] == spq_pkg::MODE_REMOVE) && empty;

  `SPQ_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CW'(N), "stored count above capacity")
  `SPQ_ASSERT_NEXT(a_ins_grows, cmd.ins, count_r == $past(count_r) + CW'(1), "insert lost")
  `SPQ_ASSERT_NEXT(a_empty_status, rem_on_empty, status_r == spq_pkg::ST_EMPTY, "empty missed")
  `SPQ_ASSERT_NOW(a_head_order, count_r >= CW'(2), cpri[0] <= cpri[1], "head out of order")

endmodule
